>>> rtl/isc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isc_pkg: shared types and constants of the insertion sorter
// Request and response payloads, operation codes, sequencer states and
// the default store depth.
// ----------------------------------------------------------------------------
package isc_pkg;

	// Default number of entries in the sorted store.
	localparam int MAX_ENTRIES_DEF = 1024;

	// Operation codes carried in the request.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// Request payload.
	typedef struct packed {
		logic        [1:0]  opcode;
		logic signed [31:0] value;
		logic        [9:0]  index;
	} req_t;

	// Response payload.
	typedef struct packed {
		logic        [10:0] position;
		logic signed [31:0] read_value;
		logic        [10:0] fill_level;
		logic        [19:0] move_count;
		logic               error_flag;
	} rsp_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_PLACE,
		ST_RDWAIT,
		ST_RESP
	} state_t;

endpackage
`default_nettype wire

>>> rtl/insertion_sort_move_counter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// insertion_sort_move_counter_top: online insertion sorter with move counter
// Sorted store in a single RAM, a sequencer and a registered response stage.
// ----------------------------------------------------------------------------
// Each request gives exactly one response. On an insert into a store that is
// neither empty nor full, the sequencer compares and moves one entry per
// cycle through the single read and write port of the store RAM until the
// new value is placed; the next request is taken once the response has been
// handed to the output register. A read passes a wait state for the RAM
// data, while an insert into an empty store, a clear, an error or an unused
// opcode goes straight to the response state. The store needs no clearing
// pass after reset: only the sequencer state, the fill count and the move
// count are reset, and the block takes requests from the first cycle. The
// move count saturates at its all-ones value.
module insertion_sort_move_counter_top import isc_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int AW = $clog2(MAX_ENTRIES);

	logic          res_valid;
	logic          res_ready;
	rsp_t          res;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	// Sorted store.
	isc_ram #(
		.WIDTH(32),
		.DEPTH(MAX_ENTRIES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sequencer.
	isc_engine #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	// Response register: loads when empty or when its transfer completes.
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// A result handed over by the sequencer shows up at the output.
	a_res_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> rsp_valid)
		else $error("result handed over but response not valid");

	// The sequencer is busy in the cycle after a request transfer.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while the sequencer was working");

	// An error response never carries read data.
	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.error_flag |-> rsp.read_value == 32'sd0)
		else $error("error response with non-zero read data");

	// The RAM is never written while the sequencer waits to respond.
	a_no_write_in_resp: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !ram_we)
		else $error("store written while a result waits");
`endif

endmodule
`default_nettype wire

>>> rtl/isc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isc_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module isc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/isc_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isc_engine: insert, read and clear sequencer
// Walks the sorted store from the top downwards on an insert, moving each
// greater entry up by one slot, one RAM read and one write per cycle.
// ----------------------------------------------------------------------------
module isc_engine import isc_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	localparam int AW = $clog2(MAX_ENTRIES)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire req_t          req,
	output logic               res_valid,
	input  wire logic          res_ready,
	output rsp_t               res,
	output logic               ram_we,
	output logic [AW-1:0]      ram_waddr,
	output logic [31:0]        ram_wdata,
	output logic [AW-1:0]      ram_raddr,
	input  wire logic [31:0]   ram_rdata
);

	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int CMPW = (CW > 10) ? CW : 10;
	localparam int LW   = (AW > 11) ? AW : 11;
	localparam int FW   = (CW > 11) ? CW : 11;

	state_t             state_q, state_d;
	logic [CW-1:0]      cnt_q;
	logic [19:0]        moves_q;
	logic [AW-1:0]      slot_q;
	logic signed [31:0] val_q;
	logic [10:0]        pos_q;
	logic [31:0]        rdv_q;
	logic               err_q;

	logic            full;
	logic            empty;
	logic            idx_ok;
	logic            greater;
	logic [CMPW-1:0] idx_ext;
	logic [CW-1:0]   cnt_m1;
	logic [19:0]     moves_inc;
	logic [LW-1:0]   slot_ext;
	logic [FW-1:0]   fill_ext;

	// Status of the store and the comparison of the entry just read.
	assign full      = (cnt_q == CW'(MAX_ENTRIES));
	assign empty     = (cnt_q == '0);
	assign idx_ext   = CMPW'(req.index);
	assign idx_ok    = (idx_ext < CMPW'(cnt_q));
	assign cnt_m1    = cnt_q - CW'(1);
	assign greater   = ($signed(ram_rdata) > val_q);
	assign moves_inc = (moves_q == '1) ? moves_q : moves_q + 20'd1;
	assign slot_ext  = LW'(slot_q);
	assign fill_ext  = FW'(cnt_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					case (req.opcode)
						OP_INSERT: begin
							if (full || empty) begin
								state_d = ST_RESP;
							end else begin
								state_d = ST_SHIFT;
							end
						end
						OP_READ: begin
							state_d = idx_ok ? ST_RDWAIT : ST_RESP;
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end
			end
			ST_SHIFT: begin
				if (!greater) begin
					state_d = ST_RESP;
				end else if (slot_q == AW'(1)) begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				state_d = ST_RESP;
			end
			ST_RDWAIT: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Handshake and RAM port outputs.
	always_comb begin
		req_ready = (state_q == ST_IDLE);
		res_valid = (state_q == ST_RESP);
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && req.opcode == OP_INSERT && !full) begin
					if (empty) begin
						ram_we    = 1'b1;
						ram_wdata = req.value;
					end else begin
						ram_raddr = cnt_m1[AW-1:0];
					end
				end else if (req_valid && req.opcode == OP_READ) begin
					ram_raddr = idx_ext[AW-1:0];
				end
			end
			ST_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = slot_q;
				if (greater) begin
					ram_wdata = ram_rdata;
					ram_raddr = slot_q - AW'(2);
				end else begin
					ram_wdata = val_q;
				end
			end
			ST_PLACE: begin
				ram_we    = 1'b1;
				ram_wdata = val_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Control state: sequencer, fill count and move count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			moves_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (req_valid && req.opcode == OP_INSERT && !full) begin
						if (empty) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							moves_q <= moves_inc;
						end
					end else if (req_valid && req.opcode == OP_CLEAR) begin
						cnt_q   <= '0;
						moves_q <= '0;
					end
				end
				ST_SHIFT: begin
					if (greater) begin
						moves_q <= moves_inc;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_PLACE: begin
					cnt_q <= cnt_q + CW'(1);
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// Item payload and result fields.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					val_q  <= req.value;
					slot_q <= cnt_q[AW-1:0];
					rdv_q  <= '0;
					case (req.opcode)
						OP_INSERT: begin
							pos_q <= '0;
							err_q <= full;
						end
						OP_READ: begin
							pos_q <= {1'b0, req.index};
							err_q <= !idx_ok;
						end
						default: begin
							pos_q <= '0;
							err_q <= 1'b0;
						end
					endcase
				end
			end
			ST_SHIFT: begin
				if (greater) begin
					slot_q <= slot_q - AW'(1);
				end else begin
					pos_q <= slot_ext[10:0];
				end
			end
			ST_PLACE: begin
				pos_q <= '0;
			end
			ST_RDWAIT: begin
				rdv_q <= ram_rdata;
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	// Result presented to the output stage.
	always_comb begin
		res.position   = pos_q;
		res.read_value = rdv_q;
		res.fill_level = fill_ext[10:0];
		res.move_count = moves_q;
		res.error_flag = err_q;
	end

endmodule
`default_nettype wire
